@@ hdl/ebcpu_pkg.sv @@
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Shared types, codes and address helpers for the 8-bit CPU cycle step.
// ----------------------------------------------------------------------------
package ebcpu_pkg;

  localparam int RAM_DEPTH = 32768;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [15:0] PAGE_MASK = 16'hff00;

  typedef enum logic [2:0] {
    OP_LD  = 3'd0,
    OP_AND = 3'd1,
    OP_OR  = 3'd2,
    OP_XOR = 3'd3,
    OP_ADD = 3'd4,
    OP_SUB = 3'd5,
    OP_ST  = 3'd6,
    OP_BR  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    MODE_D_AC    = 3'd0,
    MODE_X_AC    = 3'd1,
    MODE_YD_AC   = 3'd2,
    MODE_YX_AC   = 3'd3,
    MODE_D_X     = 3'd4,
    MODE_D_Y     = 3'd5,
    MODE_D_OUT   = 3'd6,
    MODE_YXI_OUT = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    SRC_D   = 2'd0,
    SRC_RAM = 2'd1,
    SRC_AC  = 2'd2,
    SRC_IN  = 2'd3
  } src_t;

  typedef struct packed {
    op_t   op;
    mode_t mode;
    src_t  src;
  } ctrl_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

  function automatic ctrl_t decode(input logic [7:0] ir);
    return ctrl_t'(ir);
  endfunction

  // Fold a 16-bit address into the RAM depth.
  function automatic logic [RAM_AW-1:0] fold_addr(input logic [15:0] a);
    logic [16:0] wide;
    logic [16:0] folded;
    wide   = {1'b0, a};
    folded = (wide >= 17'(RAM_DEPTH)) ? wide - 17'(RAM_DEPTH) : wide;
    return folded[RAM_AW-1:0];
  endfunction

  // RAM address used by an instruction, given the X and Y it will see.
  function automatic logic [RAM_AW-1:0] ram_addr(input logic [7:0] ir,
                                                 input logic [7:0] d,
                                                 input logic [7:0] x,
                                                 input logic [7:0] y);
    ctrl_t      c;
    logic [7:0] lo;
    logic [7:0] hi;
    c  = decode(ir);
    lo = d;
    hi = 8'h00;
    if (c.op != OP_BR) begin
      case (c.mode)
        MODE_X_AC: begin
          lo = x;
        end
        MODE_YD_AC: begin
          hi = y;
        end
        MODE_YX_AC, MODE_YXI_OUT: begin
          lo = x;
          hi = y;
        end
        default: begin
          lo = d;
        end
      endcase
    end
    return fold_addr({hi, lo});
  endfunction

endpackage

@@ hdl/ebcpu_ram.sv @@
// ----------------------------------------------------------------------------
// ebcpu_ram
// Data RAM, one write and one registered read port, write data forwarded
// when both ports hit the same address in the same cycle.
// ----------------------------------------------------------------------------
module ebcpu_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  ebcpu_pkg::ram_wr_t wr,
  input  ebcpu_pkg::ram_rd_t rd,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [ebcpu_pkg::RAM_DEPTH];
  logic [7:0] q_r;
  logic       byp_r;
  logic [7:0] byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd.en) begin
      byp_r <= wr.en && (wr.addr == rd.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

@@ hdl/eight_bit_cpu_cycle_step_top.sv @@
// ----------------------------------------------------------------------------
// eight_bit_cpu_cycle_step_top
// A result is registered, valid in the cycle after its input is accepted.
// Throughput: one transaction per cycle unless the output is held off.
// The RAM read for an instruction is issued when it is fetched, so it is
// ready when the instruction executes.
// Reset clears PC, IR, D, AC, X, Y and OUT; RAM content stays undefined
// until written, with no clearing pass.
// ----------------------------------------------------------------------------
module eight_bit_cpu_cycle_step_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // instr_byte, data_byte, input_port, floating_bus
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // fetch_pc, ac_value, x_value, y_value, out_value, ram_write_enable,
  // ram_write_address, ram_write_data, zero pad
  output logic [79:0] out_tdata
);

  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  ir_r, d_r;
  logic [7:0]  ac_r, ac_nxt;
  logic [7:0]  x_r, x_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [7:0]  outreg_r, outreg_nxt;
  logic [ebcpu_pkg::RAM_AW-1:0] addr_r, addr_nxt;
  logic        out_valid_r;
  logic [79:0] out_data_r, out_data_nxt;

  logic        in_acc;
  logic [7:0]  f_instr, f_data, f_port, f_float;
  ebcpu_pkg::ctrl_t   ctrl;
  ebcpu_pkg::ram_wr_t ram_wr;
  ebcpu_pkg::ram_rd_t ram_rd;
  logic [7:0]  ram_q;
  logic        is_st, is_br;
  logic [7:0]  bus, alu;
  logic        taken;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign f_instr = in_tdata[7:0];
  assign f_data  = in_tdata[15:8];
  assign f_port  = in_tdata[23:16];
  assign f_float = in_tdata[31:24];

  assign ctrl  = ebcpu_pkg::decode(ir_r);
  assign is_st = ctrl.op == ebcpu_pkg::OP_ST;
  assign is_br = ctrl.op == ebcpu_pkg::OP_BR;

  always_comb begin
    case (ctrl.src)
      ebcpu_pkg::SRC_D:   bus = d_r;
      ebcpu_pkg::SRC_RAM: bus = is_st ? f_float : ram_q;
      ebcpu_pkg::SRC_AC:  bus = ac_r;
      default:            bus = f_port;
    endcase
  end

  always_comb begin
    case (ctrl.op)
      ebcpu_pkg::OP_LD:  alu = bus;
      ebcpu_pkg::OP_AND: alu = ac_r & bus;
      ebcpu_pkg::OP_OR:  alu = ac_r | bus;
      ebcpu_pkg::OP_XOR: alu = ac_r ^ bus;
      ebcpu_pkg::OP_ADD: alu = ac_r + bus;
      ebcpu_pkg::OP_SUB: alu = ac_r - bus;
      default:           alu = ac_r;
    endcase
  end

  always_comb begin
    ac_nxt     = ac_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    outreg_nxt = outreg_r;
    if (!is_br) begin
      case (ctrl.mode) inside
        ebcpu_pkg::MODE_D_AC, ebcpu_pkg::MODE_X_AC,
        ebcpu_pkg::MODE_YD_AC, ebcpu_pkg::MODE_YX_AC: begin
          if (!is_st) ac_nxt = alu;
        end
        ebcpu_pkg::MODE_D_X: begin
          x_nxt = alu;
        end
        ebcpu_pkg::MODE_D_Y: begin
          y_nxt = alu;
        end
        ebcpu_pkg::MODE_D_OUT: begin
          if (!is_st) outreg_nxt = alu;
        end
        default: begin
          if (!is_st) outreg_nxt = alu;
          x_nxt = x_r + 8'd1;
        end
      endcase
    end
  end

  always_comb begin
    taken = (ctrl.mode[0] && !ac_r[7] && (ac_r != 8'h00))
         || (ctrl.mode[1] && ac_r[7])
         || (ctrl.mode[2] && (ac_r == 8'h00));
    pc_nxt = pc_r + 16'd1;
    if (is_br) begin
      if (ctrl.mode == ebcpu_pkg::MODE_D_AC) begin
        pc_nxt = {y_r, bus};
      end else if (taken) begin
        pc_nxt = (pc_r & ebcpu_pkg::PAGE_MASK) | {8'h00, bus};
      end
    end
  end

  assign addr_nxt = ebcpu_pkg::ram_addr(f_instr, f_data, x_nxt, y_nxt);

  assign ram_wr.en   = in_acc && is_st;
  assign ram_wr.addr = addr_r;
  assign ram_wr.data = bus;
  assign ram_rd.en   = in_acc;
  assign ram_rd.addr = addr_nxt;

  ebcpu_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_q)
  );

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[15:0]  = pc_nxt;
    out_data_nxt[23:16] = ac_nxt;
    out_data_nxt[31:24] = x_nxt;
    out_data_nxt[39:32] = y_nxt;
    out_data_nxt[47:40] = outreg_nxt;
    out_data_nxt[48]    = is_st;
    if (is_st) begin
      out_data_nxt[64:49] = 16'(addr_r);
      out_data_nxt[72:65] = bus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      ir_r     <= '0;
      d_r      <= '0;
      ac_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      outreg_r <= '0;
      addr_r   <= '0;
    end else if (in_acc) begin
      pc_r     <= pc_nxt;
      ir_r     <= f_instr;
      d_r      <= f_data;
      ac_r     <= ac_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      outreg_r <= outreg_nxt;
      addr_r   <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_store_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_st |=> out_tdata[48])
    else $error("store transaction without write flag");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[48] |-> out_tdata[72:49] == 24'h0)
    else $error("write fields set without a store");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(pc_r) && $stable(ac_r) && $stable(x_r))
    else $error("state moved without a transaction");

  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !is_br |=> pc_r == $past(pc_r) + 16'd1)
    else $error("program counter did not advance");

  a_ram_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |-> !ram_wr.en && !ram_rd.en)
    else $error("RAM access without a transaction");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit CPU cycle step. Each ROM word offered on
// the input stream is one machine cycle. A scoreboard steps its own copy of
// the registers and data RAM for every input transaction and compares each
// output transaction, field by field, with the oldest expected cycle. The
// stimulus is a short directed program followed by random words, shaped so
// that no RAM location is loaded before it has been stored. Both sides idle
// at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEMS     = 800;
  localparam int HOLD_OFF  = 200;
  localparam int HOLD_AT   = 300;
  localparam int IDLE_MAX  = 2000;
  localparam int DRAIN     = 10;

  localparam int RAM_DEPTH = ebcpu_pkg::RAM_DEPTH;
  localparam int RAM_AW    = ebcpu_pkg::RAM_AW;

  localparam logic [2:0] COND_GT  = 3'd1;
  localparam logic [2:0] COND_LT  = 3'd2;
  localparam logic [2:0] COND_NE  = 3'd3;
  localparam logic [2:0] COND_EQ  = 3'd4;
  localparam logic [2:0] COND_GE  = 3'd5;
  localparam logic [2:0] COND_ALL = 3'd7;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  ir;
    logic [7:0]  d;
    logic [7:0]  ac;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  outr;
  } cpu_regs_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  ac;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  outv;
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
  } cycle_result_t;

  class cpu_step_scoreboard;
    cpu_regs_t     regs = '0;
    logic [7:0]    ram [RAM_DEPTH];
    bit            written [RAM_DEPTH];
    cycle_result_t pending_cycles [$];
    int            errors;
    int            checked;
    int            stores;
    int            ram_loads;
    int            taken_branches;

    function logic [RAM_AW-1:0] ram_address(ebcpu_pkg::ctrl_t c, logic [7:0] d,
                                            logic [7:0] x, logic [7:0] y);
      logic [15:0] a;
      a = {8'h00, d};
      if (c.op != ebcpu_pkg::OP_BR) begin
        case (c.mode)
          ebcpu_pkg::MODE_X_AC: a[7:0] = x;
          ebcpu_pkg::MODE_YD_AC: a[15:8] = y;
          ebcpu_pkg::MODE_YX_AC, ebcpu_pkg::MODE_YXI_OUT: a = {y, x};
          default: ;
        endcase
      end
      return RAM_AW'(32'(a) % RAM_DEPTH);
    endfunction

    function void execute_cycle(input cpu_regs_t s, input logic [31:0] word,
                                output cpu_regs_t n, output cycle_result_t r);
      ebcpu_pkg::ctrl_t  c;
      logic              store;
      logic              taken;
      logic [2:0]        m;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        bus;
      logic [7:0]        alu;
      c     = ebcpu_pkg::ctrl_t'(s.ir);
      m     = c.mode;
      store = (c.op == ebcpu_pkg::OP_ST);
      addr  = ram_address(c, s.d, s.x, s.y);
      case (c.src)
        ebcpu_pkg::SRC_D: bus = s.d;
        ebcpu_pkg::SRC_RAM: bus = store ? word[31:24] : ram[addr];
        ebcpu_pkg::SRC_AC: bus = s.ac;
        default: bus = word[23:16];
      endcase
      case (c.op)
        ebcpu_pkg::OP_LD: alu = bus;
        ebcpu_pkg::OP_AND: alu = s.ac & bus;
        ebcpu_pkg::OP_OR: alu = s.ac | bus;
        ebcpu_pkg::OP_XOR: alu = s.ac ^ bus;
        ebcpu_pkg::OP_ADD: alu = s.ac + bus;
        ebcpu_pkg::OP_SUB: alu = s.ac - bus;
        default: alu = s.ac;
      endcase
      n    = s;
      n.pc = s.pc + 16'd1;
      n.ir = word[7:0];
      n.d  = word[15:8];
      if (c.op != ebcpu_pkg::OP_BR) begin
        case (c.mode)
          ebcpu_pkg::MODE_D_X: n.x = alu;
          ebcpu_pkg::MODE_D_Y: n.y = alu;
          ebcpu_pkg::MODE_D_OUT, ebcpu_pkg::MODE_YXI_OUT: begin
            if (!store) n.outr = alu;
          end
          default: begin
            if (!store) n.ac = alu;
          end
        endcase
        if (c.mode == ebcpu_pkg::MODE_YXI_OUT) n.x = s.x + 8'd1;
      end else if (c.mode == ebcpu_pkg::MODE_D_AC) begin
        n.pc = {s.y, bus};
      end else begin
        if (s.ac == 8'h00) taken = m[2];
        else if (s.ac[7]) taken = m[1];
        else taken = m[0];
        if (taken) n.pc = (s.pc & ebcpu_pkg::PAGE_MASK) | {8'h00, bus};
      end
      r.pc    = n.pc;
      r.ac    = n.ac;
      r.x     = n.x;
      r.y     = n.y;
      r.outv  = n.outr;
      r.we    = store;
      r.waddr = store ? 16'(addr) : 16'h0000;
      r.wdata = store ? bus : 8'h00;
    endfunction

    function void note_fetch(logic [31:0] word);
      cpu_regs_t        nxt;
      cycle_result_t    r;
      ebcpu_pkg::ctrl_t c;
      c = ebcpu_pkg::ctrl_t'(regs.ir);
      execute_cycle(regs, word, nxt, r);
      if (r.we) begin
        ram[r.waddr[RAM_AW-1:0]]     = r.wdata;
        written[r.waddr[RAM_AW-1:0]] = 1'b1;
        stores++;
      end
      if (c.src == ebcpu_pkg::SRC_RAM && c.op != ebcpu_pkg::OP_ST) ram_loads++;
      if (c.op == ebcpu_pkg::OP_BR && nxt.pc != regs.pc + 16'd1) taken_branches++;
      regs = nxt;
      pending_cycles.push_back(r);
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(logic [79:0] t);
      cycle_result_t w;
      if (pending_cycles.size() == 0) begin
        $display("%0t: unexpected result 0x%0h, expected none, got a transaction",
                 $time, t);
        errors++;
        return;
      end
      w = pending_cycles.pop_front();
      checked++;
      if (t[15:0] !== w.pc) flag("fetch_pc", w.pc, t[15:0]);
      if (t[23:16] !== w.ac) flag("ac_value", 16'(w.ac), 16'(t[23:16]));
      if (t[31:24] !== w.x) flag("x_value", 16'(w.x), 16'(t[31:24]));
      if (t[39:32] !== w.y) flag("y_value", 16'(w.y), 16'(t[39:32]));
      if (t[47:40] !== w.outv) flag("out_value", 16'(w.outv), 16'(t[47:40]));
      if (t[48] !== w.we) flag("ram_write_enable", 16'(w.we), 16'(t[48]));
      if (t[64:49] !== w.waddr) flag("ram_write_address", w.waddr, t[64:49]);
      if (t[72:65] !== w.wdata) flag("ram_write_data", 16'(w.wdata), 16'(t[72:65]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  cpu_step_scoreboard sb;
  int          sent_count;
  int          idle_cycles;
  bit          held_off;
  logic [15:0] directed_words [$];

  eight_bit_cpu_cycle_step_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pick port and bus values, then steer the word away from loading unwritten RAM.
  function automatic logic [31:0] build_word(logic [7:0] instr, logic [7:0] data);
    cpu_regs_t         ahead;
    cycle_result_t     r;
    ebcpu_pkg::ctrl_t  c;
    logic [RAM_AW-1:0] a;
    logic [7:0]        port;
    logic [7:0]        flt;
    port = 8'($urandom_range(0, 255));
    flt  = 8'($urandom_range(0, 255));
    sb.execute_cycle(sb.regs, {flt, port, 16'h0000}, ahead, r);
    c = ebcpu_pkg::ctrl_t'(instr);
    a = sb.ram_address(c, data, ahead.x, ahead.y);
    if (c.src == ebcpu_pkg::SRC_RAM && c.op != ebcpu_pkg::OP_ST && !sb.written[a] &&
        !(r.we && r.waddr[RAM_AW-1:0] == a)) begin
      if ($urandom_range(0, 1) == 1) c.op = ebcpu_pkg::OP_ST;
      else if ($urandom_range(0, 1) == 1) c.src = ebcpu_pkg::SRC_D;
      else c.src = ebcpu_pkg::SRC_IN;
    end
    return {flt, port, data, c};
  endfunction

  task automatic offer_word(logic [31:0] word);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_fetch(word);
    sent_count++;
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int         burst;
    int         gap;
    logic [7:0] instr;
    logic [7:0] data;
    sb = new;
    directed_words = '{
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_D,   8'h10},
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_RAM, 8'h11},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_RAM, 8'h10},
      {ebcpu_pkg::OP_ADD, ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_D,   8'hff},
      {ebcpu_pkg::OP_SUB, ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_D,   8'hff},
      {ebcpu_pkg::OP_AND, ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_IN,  8'h00},
      {ebcpu_pkg::OP_OR,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_AC,  8'h00},
      {ebcpu_pkg::OP_XOR, ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_IN,  8'h00},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_D_X,     ebcpu_pkg::SRC_D,   8'hff},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_D_Y,     ebcpu_pkg::SRC_D,   8'hff},
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_YXI_OUT, ebcpu_pkg::SRC_AC,  8'h00},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_D_OUT,   ebcpu_pkg::SRC_D,   8'h80},
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_YX_AC,   ebcpu_pkg::SRC_IN,  8'h00},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_YX_AC,   ebcpu_pkg::SRC_RAM, 8'h00},
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_X_AC,    ebcpu_pkg::SRC_D,   8'h5a},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_X_AC,    ebcpu_pkg::SRC_RAM, 8'h00},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_YXI_OUT, ebcpu_pkg::SRC_RAM, 8'h00},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_YD_AC,   ebcpu_pkg::SRC_RAM, 8'h00},
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_D_X,     ebcpu_pkg::SRC_AC,  8'h20},
      {ebcpu_pkg::OP_ST,  ebcpu_pkg::MODE_D_Y,     ebcpu_pkg::SRC_D,   8'h00},
      {ebcpu_pkg::OP_BR,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_D,   8'h34},
      {ebcpu_pkg::OP_BR,  COND_GT,                 ebcpu_pkg::SRC_RAM, 8'h10},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_D,   8'h00},
      {ebcpu_pkg::OP_BR,  COND_EQ,                 ebcpu_pkg::SRC_AC,  8'h00},
      {ebcpu_pkg::OP_BR,  COND_NE,                 ebcpu_pkg::SRC_IN,  8'h00},
      {ebcpu_pkg::OP_LD,  ebcpu_pkg::MODE_D_AC,    ebcpu_pkg::SRC_D,   8'h80},
      {ebcpu_pkg::OP_BR,  COND_LT,                 ebcpu_pkg::SRC_D,   8'h77},
      {ebcpu_pkg::OP_BR,  COND_GE,                 ebcpu_pkg::SRC_D,   8'h78},
      {ebcpu_pkg::OP_BR,  COND_ALL,                ebcpu_pkg::SRC_D,   8'hff}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_words[i])
      offer_word(build_word(directed_words[i][15:8], directed_words[i][7:0]));
    burst = $urandom_range(1, 30);
    while (sent_count < ITEMS) begin
      if (burst == 0) begin
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        burst = $urandom_range(1, 30);
        if (gap > 0) pause_sender(gap);
      end
      instr = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: data = 8'($urandom_range(0, 255));
        1: data = 8'($urandom_range(0, 15));
        2: data = 8'h80 | 8'($urandom_range(0, 15));
        default: data = 8'hf0 | 8'($urandom_range(0, 15));
      endcase
      offer_word(build_word(instr, data));
      burst--;
    end
    in_tvalid <= 1'b0;
    while (sb.pending_cycles.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Checked %0d cycle results from %0d fetched words after one reset.",
             sb.checked, sent_count);
    $display("Seen: %0d RAM stores, %0d RAM loads, %0d branches taken, one long output hold-off.",
             sb.stores, sb.ram_loads, sb.taken_branches);
    if (sb.errors == 0) begin
      $display("** eight_bit_cpu_cycle_step_top: PASSED **");
    end else begin
      $display("** eight_bit_cpu_cycle_step_top: FAILED **");
    end
    $finish;
  end

  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && sent_count >= HOLD_AT) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_tready <= 1'b1;
            repeat ($urandom_range(5, 40)) @(posedge clk);
          end
          1: begin
            n = $urandom_range(4, 30);
            repeat (n) begin
              out_tready <= ($urandom_range(0, 3) != 0);
              @(posedge clk);
            end
          end
          2: begin
            out_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
          end
          default: begin
            n = $urandom_range(2, 20);
            repeat (n) begin
              out_tready <= ~out_tready;
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Abort when neither side has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_MAX) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_MAX);
        $display("** eight_bit_cpu_cycle_step_top: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

@@ filelist.f @@
hdl/ebcpu_pkg.sv
hdl/ebcpu_ram.sv
hdl/eight_bit_cpu_cycle_step_top.sv
tb/tb_top.sv
